### sv/light_direction_sector_quantizer_assert.svh
// Assertion macros for the light direction sector quantizer.
`ifndef LIGHT_DIRECTION_SECTOR_QUANTIZER_ASSERT_SVH
`define LIGHT_DIRECTION_SECTOR_QUANTIZER_ASSERT_SVH

// same-cycle implication
`define LDSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ldsq: assertion failed");

// next-cycle implication
`define LDSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ldsq: assertion failed");

`endif

### sv/ldsq_pkg.sv
`timescale 1ns / 1ps

package ldsq_pkg;

	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 10;
	localparam int SECTOR_COUNT_W = 5;
	localparam int SPACING_W      = 10;

	localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_X_SPACING    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_Y_SPACING    = 2'd2;

	localparam logic [SECTOR_COUNT_W-1:0] SECTOR_COUNT_RST = 5'd8;
	localparam logic [SPACING_W-1:0]      X_SPACING_RST    = 10'd315;
	localparam logic [SPACING_W-1:0]      Y_SPACING_RST    = 10'd236;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_REWARD = 2'd2;

	localparam logic RESULT_TICK   = 1'b0;
	localparam logic RESULT_REWARD = 1'b1;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/light_direction_sector_quantizer.sv
`timescale 1ns / 1ps
// Light direction sector quantizer.
// Input channel (item_valid/item_stall): kind, sensor_select, sample_value.
//   A sample overwrites one of four stored corner readings and gives no result.
//   A tick runs CORDIC vectoring on the weighted sensor sums and quantizes the
//   angle into sector_count sectors (0 as 1, capped at MAX_SECTORS). A reward
//   request returns the previously latched minus the current direction and latches the current one.
// Output channel (result_valid/result_stall): result_kind, sector, direction,
//   reward. Config channel (cfg_valid/cfg_ready, always ready): cfg_index, cfg_data.
// Timing: a tick passes through ST_MUL, ST_PRE, ST_ITER, ST_ROUND, ST_SECT and
//   ST_FIN, doing one CORDIC step per cycle in ST_ITER in the shared add/shift
//   unit; a reward goes straight to ST_FIN; both results are registered from ST_FIN.
// Flow: the next item is taken once a tick or reward has left ST_FIN; a sample
//   leaves the state machine in ST_IDLE, so it never stalls the next item. item_stall
//   is high while a tick or reward is in progress; an item is taken while an
//   earlier result still waits.
// When the receiver stalls, the result register holds; a finished tick or
//   reward then waits in its final state until the register frees.
// Reset: stored samples, directions and sector clear to zero, registers go to
//   8 sectors, x spacing 315, y spacing 236; no result is pending.
`include "light_direction_sector_quantizer_assert.svh"

module light_direction_sector_quantizer #(
	parameter int MAX_SECTORS = 16,
	parameter int ANGLE_BITS  = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic [1:0]                            kind,
	input  logic [1:0]                            sensor_select,
	input  logic [SAMPLE_BITS-1:0]                sample_value,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic                                  result_kind,
	output logic [$clog2(MAX_SECTORS)-1:0]        sector,
	output logic signed [ANGLE_BITS-1:0]          direction,
	output logic signed [ANGLE_BITS:0]            reward,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ldsq_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [ldsq_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import ldsq_pkg::*;

	localparam int SECTOR_W = $clog2(MAX_SECTORS);
	localparam int N_W      = $clog2(MAX_SECTORS + 1);
	localparam int SUM_W    = SAMPLE_BITS + 2;
	localparam int PROD_W   = SUM_W + SPACING_W + 1;
	localparam int W        = SAMPLE_BITS + 22;
	localparam int ITER_W   = $clog2(ANGLE_BITS);
	localparam int SCALE_W  = ANGLE_BITS + N_W + 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_PRE   = 7'b0000100,
		ST_ITER  = 7'b0001000,
		ST_ROUND = 7'b0010000,
		ST_SECT  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t                      state_q;
	logic [SECTOR_COUNT_W-1:0]   sector_count_q;
	logic [SPACING_W-1:0]        x_spacing_q;
	logic [SPACING_W-1:0]        y_spacing_q;
	logic [SAMPLE_BITS-1:0]      sample_q [4];
	logic signed [ANGLE_BITS-1:0] current_direction_q;
	logic signed [ANGLE_BITS-1:0] latched_direction_q;
	logic [SECTOR_W-1:0]         current_sector_q;
	logic                        fin_reward_q;
	logic signed [ANGLE_BITS:0]  reward_val_q;
	logic                        result_valid_q;
	logic                        result_kind_q;
	logic [SECTOR_W-1:0]         sector_q;
	logic signed [ANGLE_BITS-1:0] direction_q;
	logic signed [ANGLE_BITS:0]  reward_q;

	logic signed [W-1:0]         x_q;
	logic signed [W-1:0]         y_q;
	logic [31:0]                 z_q;
	logic                        zero_q;
	logic [ITER_W-1:0]           iter_q;

	logic                        item_xfer;
	logic                        fin_go;
	logic signed [SUM_W-1:0]     sum_x;
	logic signed [SUM_W-1:0]     sum_y;
	logic signed [PROD_W-1:0]    prod_x;
	logic signed [PROD_W-1:0]    prod_y;
	logic signed [W-1:0]         dx;
	logic signed [W-1:0]         dy;
	logic [31:0]                 z_rnd;
	logic [N_W-1:0]              n_eff;
	logic [ANGLE_BITS-1:0]       u_off;
	logic [SCALE_W-1:0]          scaled;
	logic [N_W:0]                idx;
	logic [SECTOR_W-1:0]         sector_nxt;
	logic signed [ANGLE_BITS:0]  reward_nxt;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign item_xfer    = item_valid && !item_stall;
	assign fin_go       = (state_q == ST_FIN) && (!result_valid_q || !result_stall);

	assign result_valid = result_valid_q;
	assign result_kind  = result_kind_q;
	assign sector       = sector_q;
	assign direction    = direction_q;
	assign reward       = reward_q;

	always_comb begin
		sum_x = $signed({2'b00, sample_q[0]}) + $signed({2'b00, sample_q[1]})
			- $signed({2'b00, sample_q[2]}) - $signed({2'b00, sample_q[3]});
		sum_y = $signed({2'b00, sample_q[0]}) - $signed({2'b00, sample_q[1]})
			+ $signed({2'b00, sample_q[2]}) - $signed({2'b00, sample_q[3]});
		prod_x = $signed({1'b0, x_spacing_q}) * sum_x;
		prod_y = $signed({1'b0, y_spacing_q}) * sum_y;
		dx     = y_q >>> iter_q;
		dy     = x_q >>> iter_q;
		z_rnd  = z_q + (32'd1 << (31 - ANGLE_BITS));
		reward_nxt = {latched_direction_q[ANGLE_BITS-1], latched_direction_q}
			- {current_direction_q[ANGLE_BITS-1], current_direction_q};
	end

	always_comb begin
		priority if (sector_count_q == '0) begin
			n_eff = N_W'(1);
		end else if (32'(sector_count_q) > MAX_SECTORS) begin
			n_eff = N_W'(MAX_SECTORS);
		end else begin
			n_eff = N_W'(sector_count_q);
		end
		u_off  = {~current_direction_q[ANGLE_BITS-1], current_direction_q[ANGLE_BITS-2:0]};
		scaled = SCALE_W'(u_off) * SCALE_W'(n_eff) + (SCALE_W'(1) << (ANGLE_BITS - 1));
		idx    = scaled[SCALE_W-1 -: N_W+1];
		if (idx >= (N_W+1)'(n_eff)) begin
			sector_nxt = '0;
		end else begin
			sector_nxt = SECTOR_W'(idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			sector_count_q      <= SECTOR_COUNT_RST;
			x_spacing_q         <= X_SPACING_RST;
			y_spacing_q         <= Y_SPACING_RST;
			sample_q            <= '{default: '0};
			current_direction_q <= '0;
			latched_direction_q <= '0;
			current_sector_q    <= '0;
			result_valid_q      <= 1'b0;
			iter_q              <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SECTOR_COUNT: sector_count_q <= cfg_data[SECTOR_COUNT_W-1:0];
					CFG_X_SPACING:    x_spacing_q    <= cfg_data[SPACING_W-1:0];
					CFG_Y_SPACING:    y_spacing_q    <= cfg_data[SPACING_W-1:0];
					default: ;
				endcase
			end
			if (fin_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						unique case (kind)
							KIND_SAMPLE: sample_q[sensor_select] <= sample_value;
							KIND_TICK:   state_q <= ST_MUL;
							KIND_REWARD: begin
								latched_direction_q <= current_direction_q;
								state_q             <= ST_FIN;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: state_q <= ST_PRE;
				ST_PRE: begin
					iter_q  <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(ANGLE_BITS - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					current_direction_q <= zero_q ? '0 : z_rnd[31 -: ANGLE_BITS];
					state_q             <= ST_SECT;
				end
				ST_SECT: begin
					current_sector_q <= sector_nxt;
					state_q          <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			fin_reward_q <= (kind == KIND_REWARD);
			reward_val_q <= reward_nxt;
		end
		unique case (state_q)
			ST_MUL: begin
				x_q <= {{(W-PROD_W-8){prod_x[PROD_W-1]}}, prod_x, 8'b0};
				y_q <= {{(W-PROD_W-8){prod_y[PROD_W-1]}}, prod_y, 8'b0};
			end
			ST_PRE: begin
				zero_q <= (x_q == '0) && (y_q == '0);
				if (x_q[W-1]) begin
					x_q <= -x_q;
					y_q <= -y_q;
					z_q <= 32'h8000_0000;
				end else begin
					z_q <= '0;
				end
			end
			ST_ITER: begin
				if (!y_q[W-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_turn(5'(iter_q));
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_turn(5'(iter_q));
				end
			end
			default: ;
		endcase
		if (fin_go) begin
			result_kind_q <= fin_reward_q ? RESULT_REWARD : RESULT_TICK;
			sector_q      <= current_sector_q;
			direction_q   <= current_direction_q;
			reward_q      <= fin_reward_q ? reward_val_q : '0;
		end
	end

	`LDSQ_ASSERT_NEXT(a_tick_starts, clk, arst_n, item_xfer && (kind == KIND_TICK), state_q == ST_MUL)
	`LDSQ_ASSERT_NOW(a_prerot_pos, clk, arst_n, (state_q == ST_ITER) && (iter_q == '0), !x_q[W-1])
	`LDSQ_ASSERT_NEXT(a_zero_dir, clk, arst_n, (state_q == ST_ROUND) && zero_q, current_direction_q == '0)
	`LDSQ_ASSERT_NOW(a_sector_range, clk, arst_n, (state_q == ST_FIN) && !fin_reward_q, (N_W+1)'(current_sector_q) < (N_W+1)'(n_eff))

endmodule

### dv/light_direction_sector_quantizer_test.sv
`timescale 1ns / 1ps

module light_direction_sector_quantizer_test;
	import ldsq_pkg::*;

	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam logic [1:0] CFG_UNMAPPED = 2'd3;
	localparam logic [1:0] SENSOR_FL = 2'd0;
	localparam logic [1:0] SENSOR_FR = 2'd1;
	localparam logic [1:0] SENSOR_RL = 2'd2;
	localparam logic [1:0] SENSOR_RR = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 30;

	// atan(2^-i) in 2^-32 turn units
	localparam logic [31:0] ATAN_STEP [16] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861
	};

	typedef struct packed {
		logic               rkind;
		logic [3:0]         sector;
		logic signed [15:0] direction;
		logic signed [16:0] reward;
	} readout_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] kind = KIND_SAMPLE;
	logic [1:0] sensor_select = SENSOR_FL;
	logic [11:0] sample_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic result_kind;
	logic [3:0] sector;
	logic signed [15:0] direction;
	logic signed [16:0] reward;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_SECTOR_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	readout_t awaited_readouts [$];
	logic [11:0] sensor_model [4];
	logic signed [15:0] heading_now;
	logic signed [15:0] heading_at_reward;
	logic [3:0] sector_now;
	logic [4:0] sector_cfg;
	logic [9:0] x_weight;
	logic [9:0] y_weight;

	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 16;
	int recv_idle_pct = 16;
	int hold_request = 0;
	int hold_remaining = 0;

	light_direction_sector_quantizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.sensor_select(sensor_select),
		.sample_value(sample_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_kind(result_kind),
		.sector(sector),
		.direction(direction),
		.reward(reward),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic signed [15:0] light_angle(input longint xs, input longint ys);
		longint dx, dy, xa, ya;
		logic [31:0] z, rounded;
		int i;
		if (xs == 0 && ys == 0)
			return 16'sd0;
		xa = xs * 256;
		ya = ys * 256;
		z = '0;
		if (xa < 0) begin
			xa = -xa;
			ya = -ya;
			z = 32'h8000_0000;
		end
		for (i = 0; i < 16; i++) begin
			dx = ya >>> i;
			dy = xa >>> i;
			if (ya >= 0) begin
				xa += dx;
				ya -= dy;
				z += ATAN_STEP[i];
			end else begin
				xa -= dx;
				ya += dy;
				z -= ATAN_STEP[i];
			end
		end
		rounded = z + 32'h0000_8000;
		return rounded[31:16];
	endfunction

	function automatic logic [3:0] angle_sector(input logic signed [15:0] a, input logic [4:0] cnt);
		longint n, u, idx;
		n = longint'(cnt);
		if (n == 0)
			n = 1;
		if (n > 16)
			n = 16;
		u = longint'(a) + 32768;
		idx = (u * n + 32768) >> 16;
		if (idx >= n)
			idx = 0;
		return idx[3:0];
	endfunction

	task automatic track_command(input logic [1:0] k, input logic [1:0] sel,
			input logic [11:0] val);
		readout_t r;
		longint fl, fr, rl, rr, diff;
		r = '0;
		fl = longint'(sensor_model[SENSOR_FL]);
		fr = longint'(sensor_model[SENSOR_FR]);
		rl = longint'(sensor_model[SENSOR_RL]);
		rr = longint'(sensor_model[SENSOR_RR]);
		case (k)
			KIND_SAMPLE: sensor_model[sel] = val;
			KIND_TICK: begin
				heading_now = light_angle(longint'(x_weight) * (fl + fr - rl - rr),
					longint'(y_weight) * (fl - fr + rl - rr));
				sector_now = angle_sector(heading_now, sector_cfg);
				r.rkind = RESULT_TICK;
				r.sector = sector_now;
				r.direction = heading_now;
				awaited_readouts.push_back(r);
			end
			KIND_REWARD: begin
				diff = longint'(heading_at_reward) - longint'(heading_now);
				heading_at_reward = heading_now;
				r.rkind = RESULT_REWARD;
				r.sector = sector_now;
				r.direction = heading_now;
				r.reward = diff[16:0];
				awaited_readouts.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic issue_command(input logic [1:0] k, input logic [1:0] sel,
			input logic [11:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		kind = k;
		sensor_select = sel;
		sample_value = val;
		do @(posedge clk); while (item_stall);
		track_command(k, sel, val);
	endtask

	task automatic random_command();
		int r, v;
		logic [11:0] val;
		r = $urandom_range(99);
		v = $urandom_range(99);
		if (v < 8)
			val = 12'd0;
		else if (v < 16)
			val = 12'hFFF;
		else if (v < 36)
			val = sensor_model[$urandom_range(3)];
		else
			val = 12'($urandom_range(4095));
		if (r < 58)
			issue_command(KIND_SAMPLE, 2'($urandom_range(3)), val);
		else if (r < 84)
			issue_command(KIND_TICK, 2'($urandom_range(3)), 12'($urandom_range(4095)));
		else if (r < 97)
			issue_command(KIND_REWARD, 2'($urandom_range(3)), 12'($urandom_range(4095)));
		else
			issue_command(KIND_IGNORED, 2'($urandom_range(3)), 12'($urandom_range(4095)));
	endtask

	task automatic random_burst(input int count);
		repeat (count) random_command();
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid = 1'b0;
		while (awaited_readouts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SECTOR_COUNT: sector_cfg = data[4:0];
			CFG_X_SPACING: x_weight = data;
			CFG_Y_SPACING: y_weight = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_remaining = hold_request;
			hold_request = 0;
		end
		if (hold_remaining > 0) begin
			result_stall = 1'b1;
			hold_remaining--;
		end else begin
			result_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic compare_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		readout_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_readouts.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual kind %0d sector %0d",
					$time, result_kind, sector);
			end else begin
				e = awaited_readouts.pop_front();
				compare_field("result_kind", longint'(e.rkind), longint'(result_kind));
				compare_field("sector", longint'(e.sector), longint'(sector));
				compare_field("direction", longint'(e.direction), longint'(direction));
				compare_field("reward", longint'(e.reward), longint'(reward));
			end
		end
	end

	task automatic test_reset_state();
		issue_command(KIND_TICK, SENSOR_FL, 12'd0);
		issue_command(KIND_REWARD, SENSOR_FL, 12'd0);
	endtask

	task automatic test_sensor_extremes();
		issue_command(KIND_SAMPLE, SENSOR_FL, 12'hFFF);
		issue_command(KIND_TICK, SENSOR_FL, 12'd0);
		issue_command(KIND_SAMPLE, SENSOR_FR, 12'hFFF);
		issue_command(KIND_TICK, SENSOR_FL, 12'd0);
		issue_command(KIND_SAMPLE, SENSOR_RL, 12'hFFF);
		issue_command(KIND_REWARD, SENSOR_FL, 12'd0);
		issue_command(KIND_SAMPLE, SENSOR_RR, 12'hFFF);
		issue_command(KIND_TICK, SENSOR_FL, 12'd0);
		issue_command(KIND_SAMPLE, SENSOR_RL, 12'hAAA);
		issue_command(KIND_SAMPLE, SENSOR_RR, 12'h555);
		issue_command(KIND_SAMPLE, SENSOR_FL, 12'h555);
		issue_command(KIND_SAMPLE, SENSOR_FR, 12'hAAA);
		issue_command(KIND_TICK, SENSOR_FL, 12'd0);
	endtask

	// rear sensors only, equal: exactly half a turn
	task automatic test_half_turn();
		issue_command(KIND_SAMPLE, SENSOR_FL, 12'd0);
		issue_command(KIND_SAMPLE, SENSOR_FR, 12'd0);
		issue_command(KIND_SAMPLE, SENSOR_RL, 12'hFFF);
		issue_command(KIND_SAMPLE, SENSOR_RR, 12'hFFF);
		issue_command(KIND_TICK, SENSOR_FL, 12'd0);
		issue_command(KIND_REWARD, SENSOR_FL, 12'd0);
	endtask

	task automatic test_ignored_kind();
		issue_command(KIND_IGNORED, SENSOR_RR, 12'hFFF);
		issue_command(KIND_TICK, SENSOR_FL, 12'd0);
		issue_command(KIND_REWARD, SENSOR_RR, 12'hFFF);
	endtask

	task automatic test_sector_counts();
		int i;
		logic [9:0] counts [6];
		counts = '{10'd0, 10'd1, 10'd2, 10'd16, 10'd31, 10'h3F7};
		for (i = 0; i < 6; i++) begin
			settle();
			write_reg(CFG_SECTOR_COUNT, counts[i]);
			random_burst(25);
		end
	endtask

	task automatic test_spacing_extremes();
		settle();
		write_reg(CFG_X_SPACING, 10'd0);
		write_reg(CFG_Y_SPACING, 10'd1023);
		random_burst(30);
		settle();
		write_reg(CFG_X_SPACING, 10'd1023);
		write_reg(CFG_Y_SPACING, 10'd0);
		random_burst(30);
		settle();
		write_reg(CFG_X_SPACING, 10'd1);
		write_reg(CFG_Y_SPACING, 10'd1023);
		write_reg(CFG_UNMAPPED, 10'h3FF);
		random_burst(30);
		settle();
		write_reg(CFG_X_SPACING, 10'd1023);
		write_reg(CFG_Y_SPACING, 10'd1);
		write_reg(CFG_SECTOR_COUNT, 10'd16);
		random_burst(30);
	endtask

	task automatic test_result_backpressure();
		settle();
		@(posedge clk);
		hold_request = 300;
		repeat (40) begin
			if ($urandom_range(1))
				issue_command(KIND_TICK, 2'($urandom_range(3)), 12'($urandom_range(4095)));
			else
				random_command();
		end
	endtask

	task automatic test_random_traffic();
		int v;
		repeat (4) begin
			settle();
			v = $urandom_range(3);
			write_reg(CFG_SECTOR_COUNT, (v == 0) ? 10'd16 : 10'($urandom_range(1, 16)));
			write_reg(CFG_X_SPACING, (v == 1) ? 10'd1023 : 10'($urandom_range(1, 1023)));
			write_reg(CFG_Y_SPACING, (v == 2) ? 10'd1 : 10'($urandom_range(1, 1023)));
			random_burst(70);
		end
	endtask

	task automatic test_no_idle_stretch();
		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_burst(60);
		settle();
		send_idle_pct = 16;
		recv_idle_pct = 16;
	endtask

	initial begin
		sensor_model = '{default: 12'd0};
		heading_now = '0;
		heading_at_reward = '0;
		sector_now = '0;
		sector_cfg = SECTOR_COUNT_RST;
		x_weight = X_SPACING_RST;
		y_weight = Y_SPACING_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_sensor_extremes();
		test_half_turn();
		test_ignored_kind();
		test_sector_counts();
		test_spacing_extremes();
		test_result_backpressure();
		test_random_traffic();
		test_no_idle_stretch();

		settle();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
